FILE: rtl/tdpt_pkg.sv
// Shared types, constants and the control store of the trial-division primality tester.
`default_nettype none

package tdpt_pkg;

  // Dividend bits consumed by each remainder unit per cycle.
  localparam int DIGIT_BITS = 4;

  // Divisor schedule of the 6k +/- 1 scheme.
  localparam int FIRST_DIV  = 5;
  localparam int DIV_STEP   = 6;
  localparam int PAIR_OFS   = 2;
  localparam int SMALL_DIV  = 3;

  // Control store address.
  typedef logic [3:0] pc_t;

  // Jump condition select.
  typedef logic [3:0] cond_t;
  localparam cond_t C_NEXT     = 4'd0;  // never jump, fall through
  localparam cond_t C_ALWAYS   = 4'd1;  // jump unconditionally
  localparam cond_t C_NO_INPUT = 4'd2;  // no input transfer this cycle
  localparam cond_t C_TRIVIAL  = 4'd3;  // negative, small or even
  localparam cond_t C_DIV_BUSY = 4'd4;  // remainder units not yet finished
  localparam cond_t C_B_ZERO   = 4'd5;  // second divisor divides the number
  localparam cond_t C_SQ_GT    = 4'd6;  // divisor squared exceeds the number
  localparam cond_t C_ANY_ZERO = 4'd7;  // either divisor divides the number
  localparam cond_t C_OUT_BUSY = 4'd8;  // output register still occupied

  // Verdict update applied when a jump is taken.
  typedef logic [1:0] res_t;
  localparam res_t R_KEEP = 2'd0;
  localparam res_t R_TRIV = 2'd1;
  localparam res_t R_ZERO = 2'd2;
  localparam res_t R_ONE  = 2'd3;

  // Program steps.
  localparam pc_t ST_EMIT  = 4'd0;
  localparam pc_t ST_WAIT  = 4'd1;
  localparam pc_t ST_TRIV  = 4'd2;
  localparam pc_t ST_DIV3  = 4'd3;
  localparam pc_t ST_CHK3  = 4'd4;
  localparam pc_t ST_BOUND = 4'd5;
  localparam pc_t ST_DIVP  = 4'd6;
  localparam pc_t ST_CHKP  = 4'd7;
  localparam pc_t ST_ADV   = 4'd8;

  // One control word.
  typedef struct packed {
    logic  accept;    // offer in_tready, load the number and the first divisor
    logic  div_init;  // clear remainders and load the dividend shifter
    logic  div_step;  // consume one digit of the dividend
    logic  ld_loop;   // divisor 5, square 25
    logic  advance;   // divisor += 6, square updated
    logic  emit;      // hand the verdict to the output register
    cond_t cond;
    res_t  res;
    pc_t   target;
  } ctrl_t;

  // Microprogram. Emit sits at address zero so that it falls through to the wait step.
  function automatic ctrl_t ucode_rom(input pc_t pc);
    ctrl_t w;
    begin
      w = '0;
      unique case (pc)
        ST_EMIT: begin
          w.emit   = 1'b1;
          w.cond   = C_OUT_BUSY;
          w.target = ST_EMIT;
        end
        ST_WAIT: begin
          w.accept = 1'b1;
          w.cond   = C_NO_INPUT;
          w.target = ST_WAIT;
        end
        ST_TRIV: begin
          w.div_init = 1'b1;
          w.cond     = C_TRIVIAL;
          w.res      = R_TRIV;
          w.target   = ST_EMIT;
        end
        ST_DIV3: begin
          w.div_step = 1'b1;
          w.cond     = C_DIV_BUSY;
          w.target   = ST_DIV3;
        end
        ST_CHK3: begin
          w.ld_loop = 1'b1;
          w.cond    = C_B_ZERO;
          w.res     = R_ZERO;
          w.target  = ST_EMIT;
        end
        ST_BOUND: begin
          w.div_init = 1'b1;
          w.cond     = C_SQ_GT;
          w.res      = R_ONE;
          w.target   = ST_EMIT;
        end
        ST_DIVP: begin
          w.div_step = 1'b1;
          w.cond     = C_DIV_BUSY;
          w.target   = ST_DIVP;
        end
        ST_CHKP: begin
          w.advance = 1'b1;
          w.cond    = C_ANY_ZERO;
          w.res     = R_ZERO;
          w.target  = ST_EMIT;
        end
        ST_ADV: begin
          w.cond   = C_ALWAYS;
          w.target = ST_BOUND;
        end
        default: begin
          w.cond   = C_ALWAYS;
          w.target = ST_WAIT;
        end
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/trial_division_primality_test.sv
// Top level of the trial-division primality tester, driven by a small microprogram.
//
//  Channel   Direction  Ports                         Contents
//  input     in         in_tvalid/in_tready/in_tdata  candidate (signed), bits [W-1:0]
//  result    out        out_tvalid/out_tready/out_tdata  is_prime, bit 0
//
// One candidate is worked on at a time; a composite stops at its first factor.
// Each divisor pair is worked through in the two 4-bit-per-cycle remainder units
// plus three control steps.
// Reset (synchronous, active low) returns the sequencer to the wait step and empties
// the output register. A stalled result sits in the output register while the next
// candidate is taken and worked on.
`default_nettype none

module trial_division_primality_test #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [NUMBER_WIDTH-1:0] candidate, zero padding above
  input  wire logic [((NUMBER_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [0] is_prime, [7:1] zero
  output logic      [7:0]                          out_tdata
);

  localparam int DW     = NUMBER_WIDTH / 2 + 1;
  localparam int SQW    = 2 * DW;
  localparam int K      = tdpt_pkg::DIGIT_BITS;
  localparam int NSTEPS = (NUMBER_WIDTH + K - 1) / K;
  localparam int SHW    = NSTEPS * K;
  localparam int CW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;

  tdpt_pkg::pc_t   pc_r, pc_nxt;
  tdpt_pkg::ctrl_t ctrl;

  logic [NUMBER_WIDTH-1:0] n_r, n_nxt;
  logic [DW-1:0]           d_r, d_nxt;
  logic [SQW-1:0]          sq_r, sq_nxt;
  logic [SHW-1:0]          sh_r, sh_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    prime_r, prime_nxt;

  logic           in_xfer;
  logic           out_xfer;
  logic           taken;
  logic           le_three;
  logic           trivial;
  logic           triv_val;
  logic [DW-1:0]  div_b;
  logic [DW-1:0]  rem_a;
  logic [DW-1:0]  rem_b;

  // Control word of the current step.
  always_comb begin
    ctrl = tdpt_pkg::ucode_rom(pc_r);
  end

  assign in_tready = ctrl.accept;
  assign in_xfer   = in_tvalid & in_tready;
  assign out_xfer  = out_valid_r & out_tready;

  // Quick verdicts: negative numbers, numbers up to three, and even numbers.
  assign le_three = (n_r <= NUMBER_WIDTH'(3));
  assign trivial  = n_r[NUMBER_WIDTH-1] | le_three | ~n_r[0];
  assign triv_val = (n_r == NUMBER_WIDTH'(2)) || (n_r == NUMBER_WIDTH'(3));

  // Second divisor of the pair; three during the first division, when d_r is one.
  assign div_b = d_r + DW'(tdpt_pkg::PAIR_OFS);

  // Jump condition.
  always_comb begin
    unique case (ctrl.cond)
      tdpt_pkg::C_NEXT:     taken = 1'b0;
      tdpt_pkg::C_ALWAYS:   taken = 1'b1;
      tdpt_pkg::C_NO_INPUT: taken = ~in_xfer;
      tdpt_pkg::C_TRIVIAL:  taken = trivial;
      tdpt_pkg::C_DIV_BUSY: taken = (cnt_r != CW'(NSTEPS - 1));
      tdpt_pkg::C_B_ZERO:   taken = (rem_b == '0);
      tdpt_pkg::C_SQ_GT:    taken = (sq_r > SQW'(n_r));
      tdpt_pkg::C_ANY_ZERO: taken = (rem_a == '0) || (rem_b == '0);
      tdpt_pkg::C_OUT_BUSY: taken = out_valid_r & ~out_tready;
      default:              taken = 1'b0;
    endcase
  end

  // Sequencer and verdict.
  always_comb begin
    pc_nxt  = taken ? ctrl.target : pc_r + tdpt_pkg::pc_t'(1);
    res_nxt = res_r;
    if (taken) begin
      unique case (ctrl.res)
        tdpt_pkg::R_KEEP: res_nxt = res_r;
        tdpt_pkg::R_TRIV: res_nxt = triv_val;
        tdpt_pkg::R_ZERO: res_nxt = 1'b0;
        tdpt_pkg::R_ONE:  res_nxt = 1'b1;
        default:          res_nxt = res_r;
      endcase
    end
  end

  // Number, divisor and running square of the divisor.
  always_comb begin
    n_nxt  = n_r;
    d_nxt  = d_r;
    sq_nxt = sq_r;
    if (ctrl.accept && in_xfer) begin
      n_nxt = in_tdata[NUMBER_WIDTH-1:0];
      d_nxt = DW'(tdpt_pkg::SMALL_DIV - tdpt_pkg::PAIR_OFS);
    end
    if (ctrl.ld_loop) begin
      d_nxt  = DW'(tdpt_pkg::FIRST_DIV);
      sq_nxt = SQW'(tdpt_pkg::FIRST_DIV * tdpt_pkg::FIRST_DIV);
    end
    if (ctrl.advance) begin
      // (d + 6)^2 = d^2 + 12d + 36
      d_nxt  = d_r + DW'(tdpt_pkg::DIV_STEP);
      sq_nxt = sq_r + (SQW'(d_r) << 3) + (SQW'(d_r) << 2)
               + SQW'(tdpt_pkg::DIV_STEP * tdpt_pkg::DIV_STEP);
    end
  end

  // Dividend shifter and digit counter feeding the remainder units.
  always_comb begin
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    if (ctrl.div_init) begin
      sh_nxt  = SHW'(n_r);
      cnt_nxt = '0;
    end else if (ctrl.div_step) begin
      sh_nxt  = sh_r << K;
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  // Output register, loaded when the emit step gets through.
  always_comb begin
    out_valid_nxt = out_valid_r;
    prime_nxt     = prime_r;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.emit && !taken) begin
      out_valid_nxt = 1'b1;
      prime_nxt     = res_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= tdpt_pkg::ST_WAIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    sh_r    <= sh_nxt;
    res_r   <= res_nxt;
    prime_r <= prime_nxt;
  end

  // Remainder units for the two divisors of a pair.
  tdpt_rem #(.DW(DW)) u_rem_a (
    .clk     (clk),
    .init    (ctrl.div_init),
    .step    (ctrl.div_step),
    .digit   (sh_r[SHW-1 -: K]),
    .divisor (d_r),
    .rem     (rem_a)
  );

  tdpt_rem #(.DW(DW)) u_rem_b (
    .clk     (clk),
    .init    (ctrl.div_init),
    .step    (ctrl.div_step),
    .digit   (sh_r[SHW-1 -: K]),
    .divisor (div_b),
    .rem     (rem_b)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, prime_r};

  // The sequencer never leaves the programmed steps.
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= tdpt_pkg::ST_ADV)
    else $error("sequencer outside the program");

  // The running square matches the divisor whenever the bound is checked.
  a_square: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == tdpt_pkg::ST_BOUND) |-> (sq_r == SQW'(d_r) * SQW'(d_r)))
    else $error("running square out of step with divisor");

  // Remainders are fully reduced when they are inspected.
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == tdpt_pkg::ST_CHKP) |-> ((rem_a < d_r) && (rem_b < div_b)))
    else $error("remainder not below its divisor");

  // An emit step that is not held back leaves a result in the output register.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == tdpt_pkg::ST_EMIT && !(out_valid_r && !out_tready)) |=> out_tvalid)
    else $error("result lost at emit");

  // A new candidate is only taken in the wait step and is then passed to the quick check.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (pc_r == tdpt_pkg::ST_TRIV))
    else $error("accepted candidate not passed to the quick check");

endmodule

`default_nettype wire

FILE: rtl/tdpt_rem.sv
// Digit-serial remainder unit: reduces a dividend by one divisor, several bits per cycle.
`default_nettype none

module tdpt_rem #(
  parameter int DW = 17
) (
  input  wire logic                             clk,
  input  wire logic                             init,
  input  wire logic                             step,
  input  wire logic [tdpt_pkg::DIGIT_BITS-1:0]  digit,
  input  wire logic [DW-1:0]                    divisor,
  output logic      [DW-1:0]                    rem
);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] rem_nxt;
  logic [DW-1:0] part;
  logic [DW:0]   trial;

  // Restoring reduction, most significant dividend bit first.
  always_comb begin
    part  = rem_r;
    trial = '0;
    for (int k = tdpt_pkg::DIGIT_BITS - 1; k >= 0; k--) begin
      trial = {part, digit[k]};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      part = trial[DW-1:0];
    end
    if (init) begin
      rem_nxt = '0;
    end else if (step) begin
      rem_nxt = part;
    end else begin
      rem_nxt = rem_r;
    end
  end

  // Remainder register.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

  assign rem = rem_r;

endmodule

`default_nettype wire
